/* hw/rtl/srce_pkg.sv */
// shared types and constants for the sheet record cell extractor
// no dependencies
`default_nettype none

package srce_pkg;

    typedef enum logic [2:0] {
        PH_TYPE0,
        PH_TYPE1,
        PH_SIZE0,
        PH_SIZE1,
        PH_SIZE2,
        PH_SIZE3,
        PH_PAYLOAD
    } t_phase;

    localparam logic [14:0] REC_ROW  = 15'h0000;
    localparam logic [14:0] REC_RK   = 15'h0002;
    localparam logic [14:0] REC_NUM  = 15'h0005;
    localparam logic [14:0] REC_STR  = 15'h0007;
    localparam logic [14:0] REC_FSTR = 15'h0008;
    localparam logic [14:0] REC_FNUM = 15'h0009;
    localparam logic [14:0] REC_BOOL = 15'h0004;

    localparam logic [2:0] KIND_RK   = 3'd0;
    localparam logic [2:0] KIND_NUM  = 3'd1;
    localparam logic [2:0] KIND_STR  = 3'd2;
    localparam logic [2:0] KIND_FSTR = 3'd3;
    localparam logic [2:0] KIND_FNUM = 3'd4;
    localparam logic [2:0] KIND_BOOL = 3'd5;

    localparam logic [1:0] CFG_LAST_ROW    = 2'd0;
    localparam logic [1:0] CFG_COL_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_ROW_TAB_LEN = 2'd2;

    localparam logic [63:0] SENT_STRING = $realtobits(-9.999e200);
    localparam logic [63:0] SENT_FMLA   = $realtobits(-9.998e200);
    localparam logic [63:0] SENT_TRUE   = $realtobits(-9.997e200);
    localparam logic [63:0] SENT_FALSE  = $realtobits(-9.996e200);

    localparam logic [14:0] COL_CAP = 15'd16384;
    localparam int          RK_LAT  = 12;

    typedef struct packed {
        logic        cell_valid;
        logic        run_done;
        logic [11:0] row_slot;
        logic [13:0] column;
        logic [2:0]  cell_kind;
        logic [31:0] string_index;
        logic [31:0] formula_offset;
        logic [31:0] formula_length;
        logic [30:0] cell_count;
    } t_res;

endpackage

`default_nettype wire

/* hw/rtl/srce_rk_value.sv */
// rk number to ieee double, with correctly rounded divide by 100
// fixed 12 stage pipeline; uses srce_pkg
`default_nettype none

module srce_rk_value
    import srce_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic        i_rk,
    input  wire logic [31:0] i_u,
    input  wire logic [63:0] i_value,
    output logic      [63:0] o_value
);

    typedef struct packed {
        logic               sp;
        logic [63:0]        spval;
        logic               sign;
        logic [31:0]        mant;
        logic signed [12:0] xexp;
        logic [6:0]         rem;
        logic [63:0]        quo;
    } t_dv;

    typedef struct packed {
        logic        sp;
        logic [63:0] spval;
        logic        sign;
        logic [10:0] ef;
        logic [51:0] frac;
        logic        g;
        logic        st;
    } t_rnd;

    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [14:0] div8(input logic [6:0] r, input logic [7:0] bits);
        logic [7:0] t;
        logic [6:0] rr;
        logic [7:0] q;
        rr = r;
        q  = 8'd0;
        for (int i = 7; i >= 0; i--) begin
            t = {rr, bits[i]};
            if (t >= 8'd100) begin
                rr   = 7'(t - 8'd100);
                q[i] = 1'b1;
            end else begin
                rr = t[6:0];
            end
        end
        return {q, rr};
    endfunction

    logic        r_a_rk;
    logic [31:0] r_a_u;
    logic [63:0] r_a_val;
    t_dv         r_dv [9];
    t_rnd        r_rn;
    logic [63:0] r_out;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_rk  <= i_rk;
            r_a_u   <= i_u;
            r_a_val <= i_value;
        end
    end

    // decode and normalize
    logic               n_isdiv, n_isint, n_sign, n_fnan;
    logic [10:0]        n_e;
    logic [17:0]        n_f;
    logic [29:0]        n_mag;
    logic [31:0]        n_m32;
    logic [5:0]         n_lz;
    logic signed [12:0] n_xpre;
    logic [63:0]        n_base;
    t_dv                n_dv0;

    always_comb begin
        n_isdiv = r_a_u[0];
        n_isint = r_a_u[1];
        n_sign  = r_a_u[31];
        n_e     = r_a_u[30:20];
        n_f     = r_a_u[19:2];
        n_base  = {r_a_u[31:2], 2'b00, 32'd0};
        n_mag   = r_a_u[31] ? 30'(-r_a_u[31:2]) : r_a_u[31:2];
        n_fnan  = !n_isint && (n_e == 11'h7FF);
        if (n_isint) begin
            n_m32  = {2'b00, n_mag};
            n_xpre = 13'sd0;
        end else begin
            n_m32  = {(n_e != 11'd0), n_f, 13'd0};
            n_xpre = ((n_e == 11'd0) ? 13'sd1 : signed'({2'b00, n_e})) - 13'sd1054;
        end
        n_lz = lzc32(n_m32);

        n_dv0.sign = n_sign;
        n_dv0.mant = n_m32 << n_lz[4:0];
        n_dv0.xexp = n_xpre - signed'({7'd0, n_lz});
        n_dv0.rem  = 7'd0;
        n_dv0.quo  = 64'd0;
        n_dv0.sp   = !r_a_rk || !n_isdiv || n_fnan || (n_m32 == 32'd0);
        if (!r_a_rk) begin
            n_dv0.spval = r_a_val;
        end else if (n_fnan) begin
            n_dv0.spval = (n_isdiv && n_f != 18'd0) ? (n_base | 64'h0008_0000_0000_0000)
                                                   : n_base;
        end else if (n_m32 == 32'd0) begin
            n_dv0.spval = {n_sign, 63'd0};
        end else if (!n_isint) begin
            n_dv0.spval = n_base;
        end else begin
            n_dv0.spval = {n_sign, 11'(n_dv0.xexp + 13'sd1054), n_dv0.mant[30:0], 21'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0] <= n_dv0;
        end
    end

    // eight bits of the quotient per stage
    for (genvar j = 0; j < 8; j++) begin : g_div
        logic [63:0] dvd;
        logic [14:0] st;
        t_dv         nx;
        always_comb begin
            dvd     = {r_dv[j].mant, 32'd0};
            st      = div8(r_dv[j].rem, dvd[63-8*j -: 8]);
            nx      = r_dv[j];
            nx.rem  = st[6:0];
            nx.quo  = {r_dv[j].quo[55:0], st[14:7]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[j+1] <= nx;
            end
        end
    end

    // align, denormalize and collect sticky
    logic               n_sh, n_lost;
    logic [57:0]        n_qn, n_shd;
    logic signed [12:0] n_eb;
    logic [5:0]         n_d;
    t_rnd               n_rn;

    always_comb begin
        n_sh = !r_dv[8].quo[57];
        n_qn = n_sh ? {r_dv[8].quo[56:0], 1'b0} : r_dv[8].quo[57:0];
        n_eb = r_dv[8].xexp + 13'sd1048 - signed'({12'd0, n_sh});
        if (n_eb > 13'sd0) begin
            n_d     = 6'd0;
            n_rn.ef = n_eb[10:0];
        end else begin
            n_d     = 6'(13'sd1 - n_eb);
            n_rn.ef = 11'd0;
        end
        n_shd      = n_qn >> n_d;
        n_lost     = (n_shd << n_d) != n_qn;
        n_rn.sp    = r_dv[8].sp;
        n_rn.spval = r_dv[8].spval;
        n_rn.sign  = r_dv[8].sign;
        n_rn.frac  = n_shd[56:5];
        n_rn.g     = n_shd[4];
        n_rn.st    = (n_shd[3:0] != 4'd0) || n_lost || (r_dv[8].rem != 7'd0);
    end

    logic        n_up;
    logic [62:0] n_mg;

    always_comb begin
        n_up = r_rn.g && (r_rn.st || r_rn.frac[0]);
        n_mg = {r_rn.ef, r_rn.frac} + {62'd0, n_up};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rn  <= n_rn;
            r_out <= r_rn.sp ? r_rn.spval : {r_rn.sign, n_mg};
        end
    end

    assign o_value = r_out;

endmodule

`default_nettype wire

/* hw/rtl/sheet_record_cell_extractor.sv */
// sheet record cell extractor: byte-wise record parser with cell output
// results are registered; one word per cycle sustained while the output is not stalled
// row table is a 1 read / 1 write memory with registered read data
// synchronous active-low reset clears parser state and config; table contents undefined
// uses srce_pkg and srce_rk_value
`default_nettype none

module sheet_record_cell_extractor
    import srce_pkg::*;
#(
    parameter int ROW_TABLE_DEPTH = 4096
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // data_byte[7:0], table_row[19:8], table_slot[32:20]
    input  wire logic [39:0]  i_s_tdata,
    // req_type[0]
    input  wire logic [0:0]   i_s_tuser,
    input  wire logic         i_s_tlast,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // row_slot[11:0], column[25:12], cell_kind[28:26], value_bits[92:29],
    // string_index[124:93], formula_offset[156:125], formula_length[188:157],
    // cell_count[219:189]
    output logic      [223:0] o_m_tdata,
    // cell_valid[0]
    output logic      [0:0]   o_m_tuser,
    output logic              o_m_tlast,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [19:0]  i_cfg_data
);

    localparam int TAB_AW = (ROW_TABLE_DEPTH > 1) ? $clog2(ROW_TABLE_DEPTH) : 1;

    logic [19:0] r_lrw;
    logic [14:0] r_col_lim;
    logic [12:0] r_rtl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lrw     <= 20'hFFFFF;
            r_col_lim <= COL_CAP;
            r_rtl     <= 13'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LAST_ROW:    r_lrw     <= i_cfg_data;
                CFG_COL_LIMIT:   r_col_lim <= i_cfg_data[14:0];
                CFG_ROW_TAB_LEN: r_rtl     <= i_cfg_data[12:0];
                default:         ;
            endcase
        end
    end

    // parser state
    t_phase             r_phase, n_phase;
    logic [14:0]        r_type, n_type;
    logic [31:0]        r_size, n_size;
    logic [31:0]        r_remain, n_remain;
    logic [31:0]        r_start, n_start;
    logic [31:0]        r_pos, n_pos;
    logic signed [12:0] r_active, n_active;
    logic [30:0]        r_cells, n_cells;
    logic               r_stopped, n_stopped;
    logic               r_pend, n_pend;
    logic               r_pend_hit, n_pend_hit;
    logic [7:0]         r_head [16];
    logic [7:0]         n_head [16];

    logic [12:0]        r_row_tab [ROW_TABLE_DEPTH];
    logic signed [12:0] r_tab_q;
    logic               tab_we, tab_re;
    logic [TAB_AW-1:0]  tab_waddr, tab_raddr;

    logic               adv, acc;
    logic               in_req, in_last;
    logic [7:0]         in_byte;
    logic [11:0]        in_row;
    logic [12:0]        in_slot;

    logic               rec_end, res_valid, clr, is_rk;
    logic [4:0]         sz_shift;
    logic [31:0]        idx, h0, h8, h12;
    logic [14:0]        lim;
    logic               cell_ok;
    logic [63:0]        vbits;
    t_res               res;

    logic [RK_LAT-1:0]  r_vld;
    t_res               r_res [RK_LAT];
    logic [63:0]        rk_value;

    assign in_req  = i_s_tuser[0];
    assign in_last = i_s_tlast;
    assign in_byte = i_s_tdata[7:0];
    assign in_row  = i_s_tdata[19:8];
    assign in_slot = i_s_tdata[32:20];

    assign adv        = !r_vld[RK_LAT-1] || i_m_tready;
    assign o_s_tready = adv;
    assign acc        = i_s_tvalid && adv;

    always_comb begin
        n_phase    = r_phase;
        n_type     = r_type;
        n_size     = r_size;
        n_remain   = r_remain;
        n_start    = r_start;
        n_pos      = r_pos;
        n_cells    = r_cells;
        n_stopped  = r_stopped;
        n_pend     = 1'b0;
        n_pend_hit = 1'b0;
        n_head     = r_head;
        n_active   = r_active;
        if (r_pend) begin
            n_active = r_pend_hit ? r_tab_q : -13'sd1;
        end
        rec_end   = 1'b0;
        res_valid = 1'b0;
        clr       = 1'b0;
        is_rk     = 1'b0;
        sz_shift  = 5'd0;
        idx       = r_size - r_remain;
        cell_ok   = 1'b0;
        vbits     = 64'd0;
        res       = '0;
        h0        = 32'd0;
        h8        = 32'd0;
        h12       = 32'd0;
        tab_we    = 1'b0;
        tab_re    = 1'b0;
        tab_waddr = TAB_AW'(in_row);
        tab_raddr = '0;
        lim       = (r_col_lim > COL_CAP) ? COL_CAP : r_col_lim;

        if (acc && !in_req) begin
            tab_we = {20'd0, in_row} < 32'(ROW_TABLE_DEPTH);
        end

        if (acc && in_req) begin
            if (r_stopped) begin
                clr = in_last;
            end else begin
                n_pos = r_pos + 32'd1;
                unique case (r_phase)
                    PH_TYPE0: begin
                        n_type  = {8'd0, in_byte[6:0]};
                        n_size  = 32'd0;
                        n_phase = in_byte[7] ? PH_TYPE1 : PH_SIZE0;
                    end
                    PH_TYPE1: begin
                        n_type  = {in_byte, r_type[6:0]};
                        n_phase = PH_SIZE0;
                    end
                    PH_SIZE0, PH_SIZE1, PH_SIZE2, PH_SIZE3: begin
                        unique case (r_phase)
                            PH_SIZE1: sz_shift = 5'd7;
                            PH_SIZE2: sz_shift = 5'd14;
                            PH_SIZE3: sz_shift = 5'd21;
                            default:  sz_shift = 5'd0;
                        endcase
                        n_size = r_size | (32'(in_byte[6:0]) << sz_shift);
                        if (in_byte[7] && r_phase != PH_SIZE3) begin
                            n_phase = t_phase'(r_phase + 3'd1);
                        end else if (n_size == 32'd0) begin
                            rec_end = 1'b1;
                            n_phase = PH_TYPE0;
                        end else begin
                            n_remain = n_size;
                            n_start  = n_pos;
                            n_phase  = PH_PAYLOAD;
                        end
                    end
                    default: begin
                        if (idx < 32'd16) begin
                            n_head[idx[3:0]] = in_byte;
                        end
                        n_remain = r_remain - 32'd1;
                        if (n_remain == 32'd0) begin
                            rec_end = 1'b1;
                            n_phase = PH_TYPE0;
                        end
                    end
                endcase

                h0  = {n_head[3], n_head[2], n_head[1], n_head[0]};
                h8  = {n_head[11], n_head[10], n_head[9], n_head[8]};
                h12 = {n_head[15], n_head[14], n_head[13], n_head[12]};

                if (rec_end) begin
                    if (n_type == REC_ROW && n_size >= 32'd4) begin
                        if (h0 > {12'd0, r_lrw}) begin
                            res_valid     = 1'b1;
                            res.run_done  = 1'b1;
                            res.cell_count = r_cells;
                            n_stopped     = !in_last;
                        end else begin
                            n_pend     = 1'b1;
                            n_pend_hit = (h0 < {19'd0, r_rtl})
                                         && (h0 < 32'(ROW_TABLE_DEPTH));
                            tab_re     = n_pend_hit;
                            tab_raddr  = h0[TAB_AW-1:0];
                        end
                    end else if (!r_active[12]) begin
                        case (n_type)
                            REC_RK: begin
                                cell_ok       = n_size >= 32'd12;
                                res.cell_kind = KIND_RK;
                                is_rk         = 1'b1;
                            end
                            REC_NUM: begin
                                cell_ok       = n_size >= 32'd16;
                                res.cell_kind = KIND_NUM;
                                vbits         = {h12, h8};
                            end
                            REC_STR: begin
                                cell_ok          = n_size >= 32'd12;
                                res.cell_kind    = KIND_STR;
                                vbits            = SENT_STRING;
                                res.string_index = h8;
                            end
                            REC_FSTR: begin
                                cell_ok            = n_size >= 32'd12;
                                res.cell_kind      = KIND_FSTR;
                                vbits              = SENT_FMLA;
                                res.formula_offset = r_start + 32'd12;
                                res.formula_length = {h8[30:0], 1'b0};
                            end
                            REC_FNUM: begin
                                cell_ok       = n_size >= 32'd16;
                                res.cell_kind = KIND_FNUM;
                                vbits         = {h12, h8};
                            end
                            REC_BOOL: begin
                                cell_ok       = n_size >= 32'd9;
                                res.cell_kind = KIND_BOOL;
                                vbits         = (n_head[8] != 8'd0) ? SENT_TRUE : SENT_FALSE;
                            end
                            default: cell_ok = 1'b0;
                        endcase
                        if (cell_ok && h0 < {17'd0, lim}) begin
                            n_cells        = r_cells + 31'd1;
                            res_valid      = 1'b1;
                            res.cell_valid = 1'b1;
                            res.run_done   = in_last;
                            res.row_slot   = r_active[11:0];
                            res.column     = h0[13:0];
                            res.cell_count = n_cells;
                        end
                    end
                end

                if (!res.cell_valid) begin
                    res.cell_kind      = 3'd0;
                    res.string_index   = 32'd0;
                    res.formula_offset = 32'd0;
                    res.formula_length = 32'd0;
                    vbits              = 64'd0;
                    is_rk              = 1'b0;
                end
                if (in_last && !res_valid) begin
                    res_valid      = 1'b1;
                    res.run_done   = 1'b1;
                    res.cell_count = r_cells;
                end
                clr = in_last;
            end
        end

        if (clr) begin
            n_phase   = PH_TYPE0;
            n_type    = 15'd0;
            n_size    = 32'd0;
            n_remain  = 32'd0;
            n_start   = 32'd0;
            n_pos     = 32'd0;
            n_active  = -13'sd1;
            n_cells   = 31'd0;
            n_stopped = 1'b0;
            n_pend    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TYPE0;
            r_type     <= 15'd0;
            r_size     <= 32'd0;
            r_remain   <= 32'd0;
            r_start    <= 32'd0;
            r_pos      <= 32'd0;
            r_active   <= -13'sd1;
            r_cells    <= 31'd0;
            r_stopped  <= 1'b0;
            r_pend     <= 1'b0;
            r_pend_hit <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_type     <= n_type;
            r_size     <= n_size;
            r_remain   <= n_remain;
            r_start    <= n_start;
            r_pos      <= n_pos;
            r_active   <= n_active;
            r_cells    <= n_cells;
            r_stopped  <= n_stopped;
            r_pend     <= n_pend;
            r_pend_hit <= n_pend_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_row_tab[tab_waddr] <= in_slot;
        end
        if (tab_re) begin
            r_tab_q <= r_row_tab[tab_raddr];
        end
    end

    // result line, kept in step with the rk value pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[RK_LAT-2:0], (acc && res_valid)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res[0] <= res;
            for (int i = 1; i < RK_LAT; i++) begin
                r_res[i] <= r_res[i-1];
            end
        end
    end

    srce_rk_value u_rk (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_rk    (is_rk),
        .i_u     (h8),
        .i_value (vbits),
        .o_value (rk_value)
    );

    assign o_m_tvalid = r_vld[RK_LAT-1];
    assign o_m_tuser  = r_res[RK_LAT-1].cell_valid;
    assign o_m_tlast  = r_res[RK_LAT-1].run_done;
    assign o_m_tdata  = {4'd0,
                         r_res[RK_LAT-1].cell_count,
                         r_res[RK_LAT-1].formula_length,
                         r_res[RK_LAT-1].formula_offset,
                         r_res[RK_LAT-1].string_index,
                         rk_value,
                         r_res[RK_LAT-1].cell_kind,
                         r_res[RK_LAT-1].column,
                         r_res[RK_LAT-1].row_slot};

endmodule

`default_nettype wire
